// File: hw/rtl/vtid_pkg.sv
`timescale 1ns / 1ps

package vtid_pkg;

  // fixed field widths
  localparam int VALUE_W        = 32;
  localparam int ID_W           = 10;
  localparam int TABLE_SIZE_DEF = 1024;

  // one hash table slot
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] key;
    logic [ID_W-1:0]    id;
  } entry_t;

endpackage

// File: hw/rtl/vtid_home.sv
`timescale 1ns / 1ps

// home slot unit: sample value modulo the table size
module vtid_home import vtid_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int ADDR_W     = $clog2(TABLE_SIZE)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output logic               done,
  output logic [ADDR_W-1:0]  rem
);

  localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      // power of two size: the remainder is the low bits, ready at once
      assign done = start;
      assign rem  = value[ADDR_W-1:0];
    end else begin : g_recip
      // scaled reciprocal of the table size; with 2^ADDR_W >= size the
      // truncated product gives the exact quotient for any 32-bit value
      localparam int SHIFT = VALUE_W + ADDR_W;
      localparam int LO_W  = 17;
      localparam int MB_W  = (ADDR_W + 1 > LO_W) ? ADDR_W + 1 : LO_W;
      localparam int PR_W  = VALUE_W + MB_W;
      localparam int ACC_W = VALUE_W + 2 * LO_W;
      localparam logic [ACC_W-1:0] RECIP =
        ((ACC_W'(1) << SHIFT) + ACC_W'(TABLE_SIZE) - ACC_W'(1)) / ACC_W'(TABLE_SIZE);
      localparam logic [MB_W-1:0] RECIP_LO = MB_W'(RECIP[LO_W-1:0]);
      localparam logic [MB_W-1:0] RECIP_HI = MB_W'(RECIP[2*LO_W-1:LO_W]);
      localparam logic [MB_W-1:0] DIVISOR  = MB_W'(TABLE_SIZE);

      localparam logic [1:0] STEP_LO  = 2'd0;
      localparam logic [1:0] STEP_HI  = 2'd1;
      localparam logic [1:0] STEP_REM = 2'd2;

      logic               busy_r, busy_nxt;
      logic               done_r, done_nxt;
      logic [1:0]         step_r, step_nxt;
      logic [VALUE_W-1:0] val_r, val_nxt;
      logic [ACC_W-1:0]   acc_r, acc_nxt;
      logic [ADDR_W-1:0]  rem_r, rem_nxt;
      logic [VALUE_W-1:0] mul_a;
      logic [MB_W-1:0]    mul_b;
      logic [PR_W-1:0]    prod;
      logic [VALUE_W-1:0] quo;

      // one shared multiplier
      assign prod = PR_W'(mul_a) * PR_W'(mul_b);

      // low product, high product, then value minus quotient times size
      always_comb begin
        busy_nxt = busy_r;
        done_nxt = 1'b0;
        step_nxt = step_r;
        val_nxt  = val_r;
        acc_nxt  = acc_r;
        rem_nxt  = rem_r;
        quo      = VALUE_W'(acc_r >> SHIFT);
        mul_a    = val_r;
        mul_b    = RECIP_LO;
        if (start) begin
          busy_nxt = 1'b1;
          step_nxt = STEP_LO;
          val_nxt  = value;
        end else if (busy_r) begin
          unique case (step_r)
            STEP_LO: begin
              acc_nxt  = ACC_W'(prod);
              step_nxt = STEP_HI;
            end
            STEP_HI: begin
              mul_b    = RECIP_HI;
              acc_nxt  = acc_r + (ACC_W'(prod) << LO_W);
              step_nxt = STEP_REM;
            end
            STEP_REM: begin
              mul_a    = quo;
              mul_b    = DIVISOR;
              rem_nxt  = ADDR_W'(val_r - prod[VALUE_W-1:0]);
              busy_nxt = 1'b0;
              done_nxt = 1'b1;
            end
            default: begin
              busy_nxt = 1'b0;
            end
          endcase
        end
      end

      // control state
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
          step_r <= STEP_LO;
        end else begin
          busy_r <= busy_nxt;
          done_r <= done_nxt;
          step_r <= step_nxt;
        end
      end

      // datapath
      always_ff @(posedge clk) begin
        val_r <= val_nxt;
        acc_r <= acc_nxt;
        rem_r <= rem_nxt;
      end

      assign done = done_r;
      assign rem  = rem_r;
    end
  endgenerate

endmodule

// File: hw/rtl/vtid_table.sv
`timescale 1ns / 1ps

// slot memory: one write port, one registered read port
module vtid_table import vtid_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int ADDR_W     = $clog2(TABLE_SIZE)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data
);

  entry_t mem [TABLE_SIZE];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/value_to_id_dictionary.sv
`timescale 1ns / 1ps

// channel   ports                                          direction
// in        in_valid, in_ready, in_sample_value[31:0]       sample words in
// out       out_valid, out_ready, out_state_id[9:0],        dense ids out
//           out_is_new, out_table_full
//
// home slot: taken at once from the low value bits when TABLE_SIZE is a power
//   of two; other sizes wait on the multiply-based remainder unit. The probe
//   loop reads one slot per cycle from the single read port of the slot memory.
// reset: a sweep over every slot clears every valid mark; in_ready is low.
// stalls: a finished item waits in a holding register while the output register
//   is still occupied; no new item is taken until it moves on.
module value_to_id_dictionary import vtid_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_sample_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    out_state_id,
  output logic               out_is_new,
  output logic               out_table_full
);

  localparam int ADDR_W = $clog2(TABLE_SIZE);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TABLE_SIZE - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HOME  = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_HOLD  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  logic [ID_W-1:0]    next_id_r, next_id_nxt;
  logic [ID_W-1:0]    hold_id_r, hold_id_nxt;
  logic               hold_new_r, hold_new_nxt;
  logic               hold_full_r, hold_full_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic               out_new_r, out_new_nxt;
  logic               out_full_r, out_full_nxt;

  logic               home_start, home_done;
  logic [ADDR_W-1:0]  home_rem;
  logic               rd_en, wr_en;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  entry_t             rd_data, wr_data;
  logic               fin, fin_new, fin_full, out_free;
  logic [ID_W-1:0]    fin_id;

  vtid_home #(
    .TABLE_SIZE (TABLE_SIZE),
    .ADDR_W     (ADDR_W)
  ) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (home_start),
    .value (in_sample_value),
    .done  (home_done),
    .rem   (home_rem)
  );

  vtid_table #(
    .TABLE_SIZE (TABLE_SIZE),
    .ADDR_W     (ADDR_W)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // sequencer: clear sweep, home slot, probe loop, result hand-off
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    next_id_nxt   = next_id_r;
    hold_id_nxt   = hold_id_r;
    hold_new_nxt  = hold_new_r;
    hold_full_nxt = hold_full_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_id_nxt    = out_id_r;
    out_new_nxt   = out_new_r;
    out_full_nxt  = out_full_r;
    home_start    = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = addr_r;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = '{valid: 1'b1, key: key_r, id: next_id_r};
    fin           = 1'b0;
    fin_id        = '0;
    fin_new       = 1'b0;
    fin_full      = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          home_start = 1'b1;
          key_nxt    = in_sample_value;
          cnt_nxt    = '0;
          if (home_done) begin
            rd_en     = 1'b1;
            rd_addr   = home_rem;
            state_nxt = ST_PROBE;
          end else begin
            state_nxt = ST_HOME;
          end
        end
      end
      ST_HOME: begin
        if (home_done) begin
          rd_en     = 1'b1;
          rd_addr   = home_rem;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!rd_data.valid) begin
          // empty slot: insert with the next id
          wr_en       = 1'b1;
          fin         = 1'b1;
          fin_id      = next_id_r;
          fin_new     = 1'b1;
          next_id_nxt = next_id_r + ID_W'(1);
        end else if (rd_data.key == key_r) begin
          fin    = 1'b1;
          fin_id = rd_data.id;
        end else if (cnt_r == LAST) begin
          // every slot visited, none empty
          fin      = 1'b1;
          fin_full = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = (addr_r == LAST) ? '0 : addr_r + ADDR_W'(1);
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = hold_id_r;
          out_new_nxt   = hold_new_r;
          out_full_nxt  = hold_full_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // finished item goes to the output register or waits
    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_id_nxt    = fin_id;
        out_new_nxt   = fin_new;
        out_full_nxt  = fin_full;
        state_nxt     = ST_IDLE;
      end else begin
        hold_id_nxt   = fin_id;
        hold_new_nxt  = fin_new;
        hold_full_nxt = fin_full;
        state_nxt     = ST_HOLD;
      end
    end

    addr_nxt = rd_en ? rd_addr : addr_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    cnt_r       <= cnt_nxt;
    key_r       <= key_nxt;
    hold_id_r   <= hold_id_nxt;
    hold_new_r  <= hold_new_nxt;
    hold_full_r <= hold_full_nxt;
    out_id_r    <= out_id_nxt;
    out_new_r   <= out_new_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_state_id   = out_id_r;
  assign out_is_new     = out_new_r;
  assign out_table_full = out_full_r;

  // a result is never both a fresh insert and a full table
  a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_new_r && out_full_r))
    else $error("result flagged both new and full");

  // a full-table result carries id zero
  a_full_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> (out_id_r == '0))
    else $error("full-table result with nonzero id");

  // an insert only lands on a slot that read back empty
  a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == ST_PROBE) |-> !rd_data.valid)
    else $error("insert over an occupied slot");

  // each insert advances the id counter by one
  a_id_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == ST_PROBE) |=> (next_id_r == $past(next_id_r) + ID_W'(1)))
    else $error("id counter did not advance on insert");

  // no item is taken during the clearing sweep
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("item accepted during clearing sweep");

endmodule
